### sv/measurement_frame_crc_deframer_top_assert.svh
// Assertion macros for the measurement frame deframer checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef MEASUREMENT_FRAME_CRC_DEFRAMER_TOP_ASSERT_SVH
`define MEASUREMENT_FRAME_CRC_DEFRAMER_TOP_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define MFCD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed in the same cycle");

// Consequent in the cycle after the antecedent.
`define MFCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed one cycle later");

`endif

### sv/mfcd_pkg.sv
// Shared constants, result type and CRC-8 step for the measurement frame deframer.
// No dependencies.
`timescale 1ns / 1ps

package mfcd_pkg;

  localparam int GROUP_DATA_BYTES = 2;
  localparam int FRAME_BYTES      = 18;
  localparam int GROUP_BYTES      = GROUP_DATA_BYTES + 1;
  localparam int WORD_BYTES       = 4;

  localparam int POS_W    = 5;
  localparam int GRP_W    = POS_W;
  localparam int WITHIN_W = $clog2(GROUP_BYTES);

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  typedef struct packed {
    logic [31:0] co2_bits;
    logic [31:0] temperature_bits;
    logic [31:0] humidity_bits;
    logic        frame_ok;
    logic [2:0]  failed_group;
  } res_t;

  // One byte through the MSB-first CRC-8, no reflection.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### sv/mfcd_core.sv
// Frame position tracking, CRC check and word assembly for the deframer.
// Depends on mfcd_pkg.
`timescale 1ns / 1ps

module mfcd_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  logic [7:0]     rx_byte,
  input  logic           frame_start,
  output logic           emit,
  output mfcd_pkg::res_t res
);
  import mfcd_pkg::*;

  logic [POS_W-1:0]    pos_r, pos_e, pos_nxt;
  logic [WITHIN_W-1:0] within_r, within_e, within_nxt;
  logic [GRP_W-1:0]    group_r, group_e, group_nxt;
  logic [POS_W-1:0]    dcnt_r, dcnt_e, dcnt_nxt;
  logic [7:0]          crc_r, crc_e, crc_nxt;
  logic [31:0]         co2_r, co2_e, co2_nxt;
  logic [31:0]         temp_r, temp_e, temp_nxt;
  logic [31:0]         hum_r, hum_e, hum_nxt;
  logic                aborted_r, aborted_e, aborted_nxt;
  logic                crc_err;

  always_comb begin
    // A frame start clears the frame before the byte is taken.
    pos_e     = frame_start ? '0 : pos_r;
    within_e  = frame_start ? '0 : within_r;
    group_e   = frame_start ? '0 : group_r;
    dcnt_e    = frame_start ? '0 : dcnt_r;
    crc_e     = frame_start ? CRC_INIT : crc_r;
    co2_e     = frame_start ? '0 : co2_r;
    temp_e    = frame_start ? '0 : temp_r;
    hum_e     = frame_start ? '0 : hum_r;
    aborted_e = frame_start ? 1'b0 : aborted_r;

    pos_nxt     = pos_e;
    within_nxt  = within_e;
    group_nxt   = group_e;
    dcnt_nxt    = dcnt_e;
    crc_nxt     = crc_e;
    co2_nxt     = co2_e;
    temp_nxt    = temp_e;
    hum_nxt     = hum_e;
    aborted_nxt = aborted_e;
    crc_err     = 1'b0;
    emit        = 1'b0;
    res         = '0;

    if (!aborted_e) begin
      if (within_e == WITHIN_W'(GROUP_DATA_BYTES)) begin
        crc_nxt = CRC_INIT;
        if (rx_byte != crc_e) begin
          crc_err            = 1'b1;
          emit               = 1'b1;
          res.frame_ok       = 1'b0;
          res.failed_group   = group_e[2:0];
          aborted_nxt        = 1'b1;
        end
      end else begin
        crc_nxt  = crc8_update(crc_e, rx_byte);
        dcnt_nxt = dcnt_e + 1'b1;
        // Data bytes past the three words are checked but not kept.
        if (dcnt_e < POS_W'(WORD_BYTES)) begin
          co2_nxt = {co2_e[23:0], rx_byte};
        end else if (dcnt_e < POS_W'(2 * WORD_BYTES)) begin
          temp_nxt = {temp_e[23:0], rx_byte};
        end else if (dcnt_e < POS_W'(3 * WORD_BYTES)) begin
          hum_nxt = {hum_e[23:0], rx_byte};
        end
      end

      if (!crc_err) begin
        if (pos_e == POS_W'(FRAME_BYTES - 1)) begin
          emit                 = 1'b1;
          res.co2_bits         = co2_nxt;
          res.temperature_bits = temp_nxt;
          res.humidity_bits    = hum_nxt;
          res.frame_ok         = 1'b1;
          res.failed_group     = '0;
          pos_nxt              = '0;
          within_nxt           = '0;
          group_nxt            = '0;
          dcnt_nxt             = '0;
          crc_nxt              = CRC_INIT;
          co2_nxt              = '0;
          temp_nxt             = '0;
          hum_nxt              = '0;
        end else begin
          pos_nxt = pos_e + 1'b1;
          if (within_e == WITHIN_W'(GROUP_DATA_BYTES)) begin
            within_nxt = '0;
            group_nxt  = group_e + 1'b1;
          end else begin
            within_nxt = within_e + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      within_r  <= '0;
      group_r   <= '0;
      dcnt_r    <= '0;
      crc_r     <= CRC_INIT;
      co2_r     <= '0;
      temp_r    <= '0;
      hum_r     <= '0;
      aborted_r <= 1'b0;
    end else if (acc) begin
      pos_r     <= pos_nxt;
      within_r  <= within_nxt;
      group_r   <= group_nxt;
      dcnt_r    <= dcnt_nxt;
      crc_r     <= crc_nxt;
      co2_r     <= co2_nxt;
      temp_r    <= temp_nxt;
      hum_r     <= hum_nxt;
      aborted_r <= aborted_nxt;
    end
  end

endmodule

### sv/mfcd_outbuf.sv
// Two-entry result buffer: output register plus skid entry.
// Depends on mfcd_pkg.
`timescale 1ns / 1ps

module mfcd_outbuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mfcd_pkg::res_t push_res,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output mfcd_pkg::res_t out_res
);
  import mfcd_pkg::*;

  res_t main_r, main_nxt, skid_r, skid_nxt;
  logic main_v_r, main_v_nxt, skid_v_r, skid_v_nxt;
  logic pop;

  assign pop       = main_v_r && out_ready;
  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = 1'b0;
      end
    end
    // Fill the output register first, the skid entry only behind it.
    if (push) begin
      if (!main_v_nxt) begin
        main_nxt   = push_res;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_res;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### sv/measurement_frame_crc_deframer_top.sv
// Measurement frame deframer: takes one response byte per transfer and gives one result
// per frame. The CRC-8 step and the word shift run between the frame state registers and
// the result buffer, so a byte can be taken in every cycle while in_ready is high. Each
// result is registered into the two-entry result buffer on the transfer of the frame's
// last byte (ok result) or of the first failing CRC byte (error result); in_ready drops
// only while both buffer entries are waiting on out_ready.
// Depends on mfcd_pkg, mfcd_core and mfcd_outbuf.
`timescale 1ns / 1ps

module measurement_frame_crc_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_co2_bits,
  output logic [31:0] out_temperature_bits,
  output logic [31:0] out_humidity_bits,
  output logic        out_frame_ok,
  output logic [2:0]  out_failed_group
);
  import mfcd_pkg::*;

  logic acc;
  logic emit;
  logic space;
  res_t res;
  res_t out_res;

  assign in_ready = space;
  assign acc      = in_valid && in_ready;

  mfcd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .emit        (emit),
    .res         (res)
  );

  mfcd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && emit),
    .push_res  (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_co2_bits         = out_res.co2_bits;
  assign out_temperature_bits = out_res.temperature_bits;
  assign out_humidity_bits    = out_res.humidity_bits;
  assign out_frame_ok         = out_res.frame_ok;
  assign out_failed_group     = out_res.failed_group;

endmodule

### sv/mfcd_checker.sv
// Port-level checks on the deframer result channel, bound to the top level.
// Depends on mfcd_pkg and measurement_frame_crc_deframer_top_assert.svh.
`timescale 1ns / 1ps

`include "measurement_frame_crc_deframer_top_assert.svh"

module mfcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_rx_byte,
  input logic        in_frame_start,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_co2_bits,
  input logic [31:0] out_temperature_bits,
  input logic [31:0] out_humidity_bits,
  input logic        out_frame_ok,
  input logic [2:0]  out_failed_group
);
  import mfcd_pkg::*;

  localparam logic [2:0] LAST_GROUP = 3'((FRAME_BYTES - 1) / GROUP_BYTES);

  logic stalled;
  logic in_seen;
  logic words_zero;
  assign stalled    = out_valid && !out_ready;
  assign in_seen    = in_valid || in_ready || in_frame_start || (in_rx_byte != 8'h00);
  assign words_zero = (out_co2_bits == 32'd0) && (out_temperature_bits == 32'd0) &&
                      (out_humidity_bits == 32'd0);

  `MFCD_ASSERT_NEXT(a_out_hold, stalled && in_seen || stalled, out_valid)
  `MFCD_ASSERT_SAME(a_ok_group_zero, out_valid && out_frame_ok, out_failed_group == 3'd0)
  `MFCD_ASSERT_SAME(a_err_words_zero, out_valid && !out_frame_ok, words_zero)
  `MFCD_ASSERT_SAME(a_err_group_range, out_valid && !out_frame_ok, out_failed_group <= LAST_GROUP)

endmodule

bind measurement_frame_crc_deframer_top mfcd_checker u_mfcd_checker (.*);
